// ----- rtl/mrrb_pkg.sv -----
`timescale 1ns / 1ps
// Package for the multi-reader ring buffer: item and result structs,
// status and operation codes, and buffer geometry. No dependencies.
package mrrb_pkg;

    // Buffer geometry, fixed by the 4-bit slot index
    localparam int unsigned DEPTH     = 16;
    localparam int unsigned PTR_W     = 4;
    localparam int unsigned OCC_W     = 5;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned COUNT_MAX = 255;

    // Operation codes
    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } t_op;

    // Result status codes
    typedef enum logic [2:0] {
        ST_WRITTEN   = 3'd0,
        ST_REFUSED   = 3'd1,
        ST_READ_OK   = 3'd2,
        ST_NOT_READY = 3'd3,
        ST_EMPTY     = 3'd4
    } t_status;

    // One input item
    typedef struct packed {
        t_op                 op;
        logic [PTR_W-1:0]    slot_index;
        logic [BYTE_W-1:0]   write_byte;
    } t_item;

    // One result item
    typedef struct packed {
        t_status             status;
        logic [BYTE_W-1:0]   read_byte;
        logic [OCC_W-1:0]    occupancy;
    } t_result;

endpackage

// ----- rtl/mrrb_in_stage.sv -----
`timescale 1ns / 1ps
// Input register of the multi-reader ring buffer: holds one accepted item
// until the core consumes it. Depends on mrrb_pkg.
module mrrb_in_stage
    import mrrb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_item i_item,
    input  logic  i_advance,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  w_accept;

    // Stall only while a held item cannot move on this cycle
    assign o_in_stall = r_valid && !i_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Fill on a transfer, drain when the core takes the item
    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Capture payload on a transfer
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- rtl/mrrb_core.sv -----
`timescale 1ns / 1ps
// Slot store and access logic of the multi-reader ring buffer: slot arrays,
// pointers, reader count register and the combinational access step. Depends on mrrb_pkg.
module mrrb_core
    import mrrb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [BYTE_W-1:0] i_cfg_wr_data,
    input  logic              i_fire,
    input  t_item             i_item,
    output t_result           o_result
);

    logic [BYTE_W-1:0] r_slot_data  [DEPTH];
    logic [BYTE_W-1:0] r_slot_count [DEPTH];
    logic [DEPTH-1:0]  r_never_written;
    logic [DEPTH-1:0]  r_ready;
    logic [PTR_W-1:0]  r_head;
    logic [PTR_W-1:0]  r_tail;
    logic              r_full;
    logic [BYTE_W-1:0] r_reader_count;

    logic [PTR_W-1:0]  n_head;
    logic [PTR_W-1:0]  n_tail;
    logic              n_full;
    logic [PTR_W-1:0]  w_head_inc;
    logic [PTR_W-1:0]  w_addr;
    logic [BYTE_W-1:0] w_count;
    logic [BYTE_W-1:0] w_count_inc;
    logic              w_empty;
    logic              w_write_ok;
    logic              w_do_write;
    logic              w_do_read;
    logic              w_clear_ready;
    logic [PTR_W-1:0]  w_fill;

    // Select the slot this item touches: head on a write, index on a read
    assign w_addr      = (i_item.op == OP_WRITE) ? r_head : i_item.slot_index;
    assign w_count     = r_slot_count[w_addr];
    assign w_count_inc = (w_count == BYTE_W'(COUNT_MAX)) ? w_count : w_count + 1'b1;
    assign w_empty     = !r_full && (r_head == r_tail);
    assign w_head_inc  = r_head + 1'b1;

    // Occupancy after the step
    assign w_fill      = n_head - n_tail;

    // Decide the outcome of the item
    always_comb begin
        w_write_ok       = r_never_written[r_head] || (w_count >= r_reader_count);
        w_do_write       = 1'b0;
        w_do_read        = 1'b0;
        o_result.status  = ST_WRITTEN;
        o_result.read_byte = '0;
        if (i_item.op == OP_WRITE) begin
            if (w_write_ok) begin
                w_do_write      = i_fire;
                o_result.status = ST_WRITTEN;
            end else begin
                o_result.status = ST_REFUSED;
            end
        end else begin
            if (!r_ready[w_addr]) begin
                o_result.status = ST_NOT_READY;
            end else if (w_empty) begin
                o_result.status = ST_EMPTY;
            end else begin
                w_do_read          = i_fire;
                o_result.status    = ST_READ_OK;
                o_result.read_byte = r_slot_data[w_addr];
            end
        end
        w_clear_ready      = w_count_inc >= r_reader_count;
        o_result.occupancy = n_full ? OCC_W'(DEPTH) : {1'b0, w_fill};
    end

    // Advance pointers on an accepted write; tail follows when full
    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_full = r_full;
        if (i_item.op == OP_WRITE && w_write_ok) begin
            n_head = w_head_inc;
            n_tail = r_full ? r_tail + 1'b1 : r_tail;
            n_full = (w_head_inc == n_tail);
        end
    end

    // Update pointers, flags and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head          <= '0;
            r_tail          <= '0;
            r_full          <= 1'b0;
            r_never_written <= '1;
            r_ready         <= '0;
            for (int i = 0; i < DEPTH; i++) begin
                r_slot_count[i] <= '0;
            end
        end else begin
            if (w_do_write) begin
                r_head                  <= n_head;
                r_tail                  <= n_tail;
                r_full                  <= n_full;
                r_slot_count[w_addr]    <= '0;
                r_never_written[w_addr] <= 1'b0;
                r_ready[w_addr]         <= 1'b1;
            end else if (w_do_read) begin
                r_slot_count[w_addr] <= w_count_inc;
                if (w_clear_ready) begin
                    r_ready[w_addr] <= 1'b0;
                end
            end
        end
    end

    // Store the byte on a write
    always_ff @(posedge i_clk) begin
        if (w_do_write) begin
            r_slot_data[w_addr] <= i_item.write_byte;
        end
    end

    // Reader count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reader_count <= BYTE_W'(1);
        end else if (i_cfg_wr_en) begin
            r_reader_count <= i_cfg_wr_data;
        end
    end

endmodule

// ----- rtl/multi_reader_ring_buffer.sv -----
`timescale 1ns / 1ps
// Top level of the multi-reader ring buffer: input stage, core and result
// register. Depends on mrrb_pkg, mrrb_in_stage and mrrb_core.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one access: a write of
//   i_write_byte at the head slot, or a read of slot i_slot_index. Each
//   access gives exactly one result on the output channel (o_out_valid /
//   i_out_stall): status, read byte and occupancy after the access.
//   An access passes the input register and then the result register.
//   Throughput is one access per cycle while the receiver does not stall;
//   the step reads and updates the slot flags, counts and pointers
//   combinationally between the two registers.
//   The configuration port (i_cfg_wr_en / i_cfg_wr_data) sets the number of
//   readers per slot; write it while no access is in flight.
//   Reset clears all pointers, ready marks and read counts, marks every slot
//   as never written and sets the reader count to one. Slot data is not
//   cleared. While the receiver stalls, the result holds and one further
//   access is taken into the input register; then o_in_stall rises.
module multi_reader_ring_buffer
    import mrrb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [BYTE_W-1:0]   i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_operation,
    input  logic [PTR_W-1:0]    i_slot_index,
    input  logic [BYTE_W-1:0]   i_write_byte,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [2:0]          o_status,
    output logic [BYTE_W-1:0]   o_read_byte,
    output logic [OCC_W-1:0]    o_occupancy
);

    t_item   w_in_item;
    t_item   w_item;
    logic    w_item_valid;
    logic    w_fire;
    t_result w_result;
    t_result r_result;
    logic    r_out_valid;
    logic    n_out_valid;

    assign w_in_item.op         = t_op'(i_operation);
    assign w_in_item.slot_index = i_slot_index;
    assign w_in_item.write_byte = i_write_byte;

    mrrb_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_item     (w_in_item),
        .i_advance  (w_fire),
        .o_valid    (w_item_valid),
        .o_item     (w_item)
    );

    // Step the item when the result register is free or draining
    assign w_fire = w_item_valid && (!r_out_valid || !i_out_stall);

    mrrb_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fire        (w_fire),
        .i_item        (w_item),
        .o_result      (w_result)
    );

    // Result register: load on a step, drop after a transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_fire) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_result.status;
    assign o_read_byte = r_result.read_byte;
    assign o_occupancy = r_result.occupancy;

endmodule

// ----- rtl/mrrb_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the multi-reader ring buffer and its bind to the
// top level. Depends on mrrb_pkg and multi_reader_ring_buffer.
module mrrb_checker
    import mrrb_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [2:0]        o_status,
    input logic [BYTE_W-1:0] o_read_byte,
    input logic [OCC_W-1:0]  o_occupancy
);

    // No result survives reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Read byte is zero unless the read succeeded
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_READ_OK) |-> (o_read_byte == '0))
        else $error("read byte nonzero without a successful read");

    // A successful write leaves at least one filled slot, never above depth
    a_write_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_WRITTEN) |->
        (o_occupancy != '0 && o_occupancy <= OCC_W'(DEPTH)))
        else $error("occupancy wrong after write");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_status) && $stable(o_read_byte)
         && $stable(o_occupancy)))
        else $error("stalled result changed");

endmodule

bind multi_reader_ring_buffer mrrb_checker u_mrrb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_status    (o_status),
    .o_read_byte (o_read_byte),
    .o_occupancy (o_occupancy)
);

// ----- verif/tb_multi_reader_ring_buffer.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for multi_reader_ring_buffer: directed and random
// accesses against an in-bench prediction of the buffer. Depends on mrrb_pkg and multi_reader_ring_buffer.
module tb_multi_reader_ring_buffer;
    import mrrb_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 185;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic [BYTE_W-1:0]   i_cfg_wr_data;
    logic                i_in_valid;
    logic                o_in_stall;
    logic                i_operation;
    logic [PTR_W-1:0]    i_slot_index;
    logic [BYTE_W-1:0]   i_write_byte;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [2:0]          o_status;
    logic [BYTE_W-1:0]   o_read_byte;
    logic [OCC_W-1:0]    o_occupancy;

    multi_reader_ring_buffer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_slot_index  (i_slot_index),
        .i_write_byte  (i_write_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_read_byte   (o_read_byte),
        .o_occupancy   (o_occupancy)
    );

    // Predicted buffer contents and pointers
    logic [BYTE_W-1:0]   slot_byte   [DEPTH];
    logic [7:0]          slot_reads  [DEPTH];
    bit                  slot_unused [DEPTH];
    bit                  slot_ready  [DEPTH];
    logic [PTR_W-1:0]    head_ptr;
    logic [PTR_W-1:0]    tail_ptr;
    bit                  is_full;
    logic [7:0]          readers_needed;

    t_result             pending_results[$];
    int                  error_count;
    int                  cycle_count;
    int                  n_written, n_refused, n_read_ok, n_not_ready, n_empty;
    bit                  sender_gaps;
    bit                  receiver_stalls;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Idle length: mostly short, now and then long
    function automatic int idle_length();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Advance the predicted buffer by one access and return its result
    function automatic t_result apply_access(t_item acc);
        t_result          res;
        logic [PTR_W-1:0] s;
        res.status    = ST_WRITTEN;
        res.read_byte = '0;
        if (acc.op == OP_WRITE) begin
            s = head_ptr;
            if (slot_unused[s] || slot_reads[s] >= readers_needed) begin
                slot_byte[s]   = acc.write_byte;
                slot_reads[s]  = '0;
                slot_unused[s] = 1'b0;
                slot_ready[s]  = 1'b1;
                if (is_full)
                    tail_ptr = tail_ptr + 1'b1;
                head_ptr = head_ptr + 1'b1;
                is_full  = (head_ptr == tail_ptr);
                n_written++;
            end else begin
                res.status = ST_REFUSED;
                n_refused++;
            end
        end else begin
            s = acc.slot_index;
            if (!slot_ready[s]) begin
                res.status = ST_NOT_READY;
                n_not_ready++;
            end else if (!is_full && head_ptr == tail_ptr) begin
                res.status = ST_EMPTY;
                n_empty++;
            end else begin
                res.status    = ST_READ_OK;
                res.read_byte = slot_byte[s];
                if (slot_reads[s] < COUNT_MAX)
                    slot_reads[s] = slot_reads[s] + 1'b1;
                if (slot_reads[s] >= readers_needed)
                    slot_ready[s] = 1'b0;
                n_read_ok++;
            end
        end
        res.occupancy = is_full ? OCC_W'(DEPTH) : {1'b0, head_ptr - tail_ptr};
        return res;
    endfunction

    // Slot to read: usually one that still holds unread data
    function automatic logic [PTR_W-1:0] pick_read_slot();
        int live[$];
        for (int i = 0; i < DEPTH; i++)
            if (slot_ready[i])
                live = {live, i};
        if (live.size() > 0 && $urandom_range(0, 3) != 0)
            return PTR_W'(live[$urandom_range(0, live.size() - 1)]);
        return PTR_W'($urandom_range(0, DEPTH - 1));
    endfunction

    // Offer one access, hold it until the transfer, then predict its result
    task automatic send_access(input t_op op, input logic [PTR_W-1:0] idx,
                               input logic [BYTE_W-1:0] data);
        int    gap;
        t_item acc;
        gap = (sender_gaps && $urandom_range(0, 3) == 0) ? idle_length() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        acc.op         = op;
        acc.slot_index = idx;
        acc.write_byte = data;
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_slot_index <= idx;
        i_write_byte <= data;
        do @(posedge i_clk); while (o_in_stall);
        pending_results = {pending_results, apply_access(acc)};
    endtask

    // Stop offering and wait until every predicted result has come out
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write the reader count once the pipeline is empty
    task automatic set_reader_count(input logic [7:0] value);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en    <= 1'b0;
        readers_needed = value;
    endtask

    // Fill from reset with a single reader, hit the full refusal and reuse
    task automatic test_fill_single_reader();
        send_access(OP_READ, 4'd5, 8'h00);
        for (int i = 0; i < DEPTH; i++) begin
            case (i)
                0:       send_access(OP_WRITE, 4'd0, 8'h00);
                1:       send_access(OP_WRITE, 4'd15, 8'hFF);
                2:       send_access(OP_WRITE, 4'd0, 8'hA5);
                3:       send_access(OP_WRITE, 4'd15, 8'h5A);
                default: send_access(OP_WRITE, 4'd0, BYTE_W'(i * 17));
            endcase
        end
        send_access(OP_WRITE, 4'd0, 8'h3C);
        send_access(OP_READ, 4'd0, 8'hFF);
        send_access(OP_READ, 4'd0, 8'h00);
        send_access(OP_WRITE, 4'd9, 8'hC3);
        send_access(OP_READ, 4'd15, 8'h00);
    endtask

    // Lower the reader count under a slot's read count so the slot frees up
    task automatic test_reader_count_lowered();
        set_reader_count(8'd3);
        send_access(OP_READ, 4'd1, 8'h00);
        send_access(OP_READ, 4'd1, 8'h00);
        send_access(OP_WRITE, 4'd0, 8'h81);
        set_reader_count(8'd1);
        send_access(OP_WRITE, 4'd0, 8'h7E);
    endtask

    // Reader count at zero and at its maximum
    task automatic test_reader_count_extremes();
        set_reader_count(8'd0);
        send_access(OP_WRITE, 4'd0, 8'h11);
        send_access(OP_READ, 4'd2, 8'h00);
        set_reader_count(8'd255);
        send_access(OP_WRITE, 4'd0, 8'h22);
    endtask

    // Random traffic over a series of reader counts and idling patterns
    task automatic test_random_traffic();
        logic [7:0] counts[8];
        counts = '{8'd1, 8'd2, 8'd3, 8'd0, 8'd5, 8'd255, 8'd2, 8'd0};
        counts[7] = 8'($urandom_range(1, 255));
        for (int p = 0; p < 8; p++) begin
            set_reader_count(counts[p]);
            sender_gaps     = (p % 3 != 0);
            receiver_stalls = (p % 3 != 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 35)
                    send_access(OP_WRITE, PTR_W'($urandom_range(0, DEPTH - 1)),
                                BYTE_W'($urandom_range(0, 255)));
                else
                    send_access(OP_READ, pick_read_slot(),
                                BYTE_W'($urandom_range(0, 255)));
            end
        end
    endtask

    // Receiver stalls: runs of random length, off in quiet phases
    initial begin
        int left;
        left = 0;
        i_out_stall <= 1'b0;
        forever @(posedge i_clk) begin
            if (left > 0) begin
                i_out_stall <= 1'b1;
                left--;
            end else if (receiver_stalls && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                left = idle_length() - 1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no access outstanding: status %0d", o_status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    error_count++;
                end
                if (o_read_byte !== want.read_byte) begin
                    $error("read_byte: expected 0x%02h, got 0x%02h",
                           want.read_byte, o_read_byte);
                    error_count++;
                end
                if (o_occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d",
                           want.occupancy, o_occupancy);
                    error_count++;
                end
            end
        end
    end

    // Main sequence
    initial begin
        cycle_count     = 0;
        error_count     = 0;
        n_written       = 0;
        n_refused       = 0;
        n_read_ok       = 0;
        n_not_ready     = 0;
        n_empty         = 0;
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        for (int i = 0; i < DEPTH; i++) begin
            slot_byte[i]   = '0;
            slot_reads[i]  = '0;
            slot_unused[i] = 1'b1;
            slot_ready[i]  = 1'b0;
        end
        head_ptr       = '0;
        tail_ptr       = '0;
        is_full        = 1'b0;
        readers_needed = 8'd1;

        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        i_in_valid    <= 1'b0;
        i_operation   <= OP_WRITE;
        i_slot_index  <= '0;
        i_write_byte  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_fill_single_reader();
        test_reader_count_lowered();
        test_reader_count_extremes();
        test_random_traffic();

        drain();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d accesses over reader counts 0 to 255:",
                 n_written + n_refused + n_read_ok + n_not_ready + n_empty);
        $display("  %0d stored, %0d refused, %0d reads with data, %0d unready, %0d empty",
                 n_written, n_refused, n_read_ok, n_not_ready, n_empty);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
